// File: hdl/rgu_pkg.sv
// ----------------------------------------------------------------------------
// rgu_pkg
// Shared constants and types for the rectangle geometry unit.
// ----------------------------------------------------------------------------
package rgu_pkg;

  // Default coordinate width
  localparam int unsigned RGU_COORD_BITS = 16;

  // Quotient bits resolved per divider pipeline stage
  localparam int unsigned RGU_DIV_STEP = 3;

  localparam int unsigned RGU_CMD_W = 2;

  typedef enum logic [RGU_CMD_W-1:0] {
    CMD_OVERLAP   = 2'd0,
    CMD_INTERSECT = 2'd1,
    CMD_UNION     = 2'd2,
    CMD_LINE      = 2'd3
  } rgu_cmd_e;

endpackage

// File: hdl/rgu_if.sv
// ----------------------------------------------------------------------------
// rgu_in_if / rgu_out_if
// Valid/ready channels carrying geometry requests and results.
// ----------------------------------------------------------------------------
interface rgu_in_if import rgu_pkg::*; #(
  parameter int unsigned COORD_BITS = RGU_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [RGU_CMD_W-1:0]         cmd;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic [COORD_BITS-2:0]        a_w;
  logic [COORD_BITS-2:0]        a_h;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_w;
  logic signed [COORD_BITS-1:0] b_h;

  modport source (output valid, cmd, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  input ready);
  modport sink   (input valid, cmd, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  output ready);
endinterface

interface rgu_out_if import rgu_pkg::*; #(
  parameter int unsigned COORD_BITS = RGU_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] r_x;
  logic signed [COORD_BITS-1:0] r_y;
  logic [COORD_BITS-1:0]        r_w;
  logic [COORD_BITS-1:0]        r_h;
  logic                         hit;

  modport source (output valid, r_x, r_y, r_w, r_h, hit, input ready);
  modport sink   (input valid, r_x, r_y, r_w, r_h, hit, output ready);
endinterface

// File: hdl/rect_geometry_unit.sv
// ----------------------------------------------------------------------------
// rect_geometry_unit
// Overlap, intersect, union and line hit test on axis-aligned rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per transaction: a command, rectangle A and
//   either rectangle B or the two endpoints of a line. out_o returns one
//   result per transaction (rectangle plus hit flag) in request order.
//   Throughput: one transaction per cycle for every command while out_o
//   accepts results. The depth is set by the two parallel crossing
//   dividers, which resolve three quotient bits per stage.
//   Stages: operand sums, compares and line prechecks, multiply and size
//   saturation, the divider stages, then the final crossing compare into
//   the output register.
//   Each stage advances when it is empty or its successor advances, so a
//   stalled receiver holds the output register and bubbles upstream still
//   close up; in_i.ready drops only when every stage holds a transaction.
//   Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module rect_geometry_unit import rgu_pkg::*; #(
  parameter int unsigned COORD_BITS = RGU_COORD_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rgu_in_if.sink   in_i,
  rgu_out_if.source out_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned E     = C + 2;          // working signed width
  localparam int unsigned QW    = 2 * C + 1;      // product / quotient width
  localparam int unsigned QS    = QW + 2;         // signed compare width
  localparam int unsigned NDIV  = (QW + RGU_DIV_STEP - 1) / RGU_DIV_STEP;
  localparam int unsigned NST   = NDIV + 4;       // total stages
  localparam int unsigned SA    = 0;
  localparam int unsigned SB    = 1;
  localparam int unsigned SC    = 2;
  localparam int unsigned SD0   = 3;
  localparam int unsigned SOUT  = NST - 1;
  localparam logic signed [E-1:0] OneE = E'(1);

  typedef struct packed {
    rgu_cmd_e          cmd;
    logic signed [E-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [E-1:0] ar, ab, br, bb, dx, dy, lox, hix, loy, hiy;
  } pa_t;

  typedef struct packed {
    logic signed [E-1:0] sx, ex, sy, ey;
    logic                hit, pend;
    logic [C-1:0]        dxm, dym;
    logic [C:0]          exm, eym;
    logic signed [E-1:0] lx, hx, ly, hy;
  } pb_t;

  typedef struct packed {
    logic [C-1:0]        rx, ry, rw, rh;
    logic                hit, pend;
    logic signed [E-1:0] lx, hx, ly, hy;
  } pd_t;

  typedef struct packed {
    logic [C-1:0] rx, ry, rw, rh;
    logic         hit;
  } po_t;

  function automatic logic [C-1:0] sat_size(input logic signed [E:0] v);
    if (v[E]) begin
      return '0;
    end else if (|v[E-1:C]) begin
      return '1;
    end
    return v[C-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic [NST-1:0] valid_q;
  logic [NST-1:0] take;

  always_comb begin
    take[NST-1] = !valid_q[NST-1] || out_o.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      take[i] = !valid_q[i] || take[i+1];
    end
  end

  assign in_i.ready = take[SA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (take[0]) valid_q[0] <= in_i.valid;
      for (int i = 1; i < NST; i++) begin
        if (take[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: widen operands, edge sums and line differences
  // --------------------------------------------------------------------------
  pa_t pa_d, pa_q;

  always_comb begin
    pa_d.cmd = rgu_cmd_e'(in_i.cmd);
    pa_d.ax  = E'(in_i.a_x);
    pa_d.ay  = E'(in_i.a_y);
    pa_d.aw  = E'(in_i.a_w);
    pa_d.ah  = E'(in_i.a_h);
    pa_d.bx  = E'(in_i.b_x);
    pa_d.by  = E'(in_i.b_y);
    pa_d.bw  = E'(in_i.b_w);
    pa_d.bh  = E'(in_i.b_h);
    pa_d.ar  = pa_d.ax + pa_d.aw;
    pa_d.ab  = pa_d.ay + pa_d.ah;
    pa_d.br  = pa_d.bx + pa_d.bw;
    pa_d.bb  = pa_d.by + pa_d.bh;
    pa_d.dx  = pa_d.bw - pa_d.bx;
    pa_d.dy  = pa_d.bh - pa_d.by;
    pa_d.lox = pa_d.ax - pa_d.bx;
    pa_d.hix = pa_d.ax + pa_d.aw - pa_d.bx;
    pa_d.loy = pa_d.ay - pa_d.by;
    pa_d.hiy = pa_d.ay + pa_d.ah - pa_d.by;
  end

  always_ff @(posedge clk_i) begin
    if (take[SA]) pa_q <= pa_d;
  end

  // --------------------------------------------------------------------------
  // Stage B: compares, result span selection, line prechecks and operands
  // --------------------------------------------------------------------------
  pb_t pb_d, pb_q;

  always_comb begin : p_stage_b
    logic overlap, in1, in2, rej, axis, line_hit, line_pend, nx, ny;
    logic signed [E-1:0] exd, eyd, exa, eya, dxa, dya;

    overlap = (pa_q.ar > pa_q.bx) && (pa_q.ax < pa_q.br) &&
              (pa_q.ab > pa_q.by) && (pa_q.ay < pa_q.bb);

    // Line endpoints: start (bx, by), end (bw, bh)
    in1 = (pa_q.bx >= pa_q.ax) && (pa_q.bx < pa_q.ar) &&
          (pa_q.by >= pa_q.ay) && (pa_q.by < pa_q.ab);
    in2 = (pa_q.bw >= pa_q.ax) && (pa_q.bw < pa_q.ar) &&
          (pa_q.bh >= pa_q.ay) && (pa_q.bh < pa_q.ab);
    rej = ((pa_q.bx < pa_q.ax) && (pa_q.bw < pa_q.ax)) ||
          ((pa_q.by < pa_q.ay) && (pa_q.bh < pa_q.ay)) ||
          ((pa_q.bx >= pa_q.ar) && (pa_q.bw >= pa_q.ar)) ||
          ((pa_q.by >= pa_q.ab) && (pa_q.bh >= pa_q.ab));
    axis = (pa_q.dx == '0) || (pa_q.dy == '0);

    line_hit  = in1 || in2 || (!rej && axis);
    line_pend = !in1 && !in2 && !rej && !axis;

    // Distance from line start to the near vertical / horizontal edge
    exd = (pa_q.bx < pa_q.ax) ? pa_q.lox : pa_q.hix;
    eyd = (pa_q.by < pa_q.ay) ? pa_q.loy : pa_q.hiy;
    exa = exd[E-1] ? -exd : exd;
    eya = eyd[E-1] ? -eyd : eyd;
    dxa = pa_q.dx[E-1] ? -pa_q.dx : pa_q.dx;
    dya = pa_q.dy[E-1] ? -pa_q.dy : pa_q.dy;

    pb_d.exm = exa[C:0];
    pb_d.eym = eya[C:0];
    pb_d.dxm = dxa[C-1:0];
    pb_d.dym = dya[C-1:0];

    // Quotient sign per crossing; fold it into the accept window
    nx = pa_q.dy[E-1] ^ exd[E-1] ^ pa_q.dx[E-1];
    ny = pa_q.dx[E-1] ^ eyd[E-1] ^ pa_q.dy[E-1];
    pb_d.lx = nx ? OneE - pa_q.hiy : pa_q.loy;
    pb_d.hx = nx ? OneE - pa_q.loy : pa_q.hiy;
    pb_d.ly = ny ? OneE - pa_q.hix : pa_q.lox;
    pb_d.hy = ny ? OneE - pa_q.lox : pa_q.hix;

    // Default: result is rectangle A, no hit
    pb_d.sx   = pa_q.ax;
    pb_d.ex   = pa_q.ar;
    pb_d.sy   = pa_q.ay;
    pb_d.ey   = pa_q.ab;
    pb_d.hit  = 1'b0;
    pb_d.pend = 1'b0;

    unique case (pa_q.cmd)
      CMD_OVERLAP: begin
        pb_d.hit = overlap;
      end
      CMD_INTERSECT: begin
        pb_d.sx = (pa_q.ax > pa_q.bx) ? pa_q.ax : pa_q.bx;
        pb_d.ex = (pa_q.ar < pa_q.br) ? pa_q.ar : pa_q.br;
        pb_d.sy = (pa_q.ay > pa_q.by) ? pa_q.ay : pa_q.by;
        pb_d.ey = (pa_q.ab < pa_q.bb) ? pa_q.ab : pa_q.bb;
      end
      CMD_UNION: begin
        if ((pa_q.bw != '0) && (pa_q.bh != '0)) begin
          if ((pa_q.aw == '0) || (pa_q.ah == '0)) begin
            pb_d.sx = pa_q.bx;
            pb_d.ex = pa_q.br;
            pb_d.sy = pa_q.by;
            pb_d.ey = pa_q.bb;
          end else begin
            pb_d.sx = (pa_q.ax < pa_q.bx) ? pa_q.ax : pa_q.bx;
            pb_d.ex = (pa_q.ar > pa_q.br) ? pa_q.ar : pa_q.br;
            pb_d.sy = (pa_q.ay < pa_q.by) ? pa_q.ay : pa_q.by;
            pb_d.ey = (pa_q.ab > pa_q.bb) ? pa_q.ab : pa_q.bb;
          end
        end
      end
      CMD_LINE: begin
        pb_d.hit  = line_hit;
        pb_d.pend = line_pend;
      end
      default: begin
        pb_d.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take[SB]) pb_q <= pb_d;
  end

  // --------------------------------------------------------------------------
  // Stage C: crossing products, result sizes with saturation
  // --------------------------------------------------------------------------
  pd_t          pc_d, pc_q;
  logic [QW-1:0] px_d, py_d, px_q, py_q;
  logic [C-1:0]  dvx_q, dvy_q;

  always_comb begin
    px_d      = QW'(pb_q.dym * pb_q.exm);
    py_d      = QW'(pb_q.dxm * pb_q.eym);
    pc_d.rx   = pb_q.sx[C-1:0];
    pc_d.ry   = pb_q.sy[C-1:0];
    pc_d.rw   = sat_size((E+1)'(pb_q.ex) - (E+1)'(pb_q.sx));
    pc_d.rh   = sat_size((E+1)'(pb_q.ey) - (E+1)'(pb_q.sy));
    pc_d.hit  = pb_q.hit;
    pc_d.pend = pb_q.pend;
    pc_d.lx   = pb_q.lx;
    pc_d.hx   = pb_q.hx;
    pc_d.ly   = pb_q.ly;
    pc_d.hy   = pb_q.hy;
  end

  always_ff @(posedge clk_i) begin
    if (take[SC]) begin
      pc_q  <= pc_d;
      px_q  <= px_d;
      py_q  <= py_d;
      dvx_q <= pb_q.dxm;
      dvy_q <= pb_q.dym;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: both crossings in parallel, side data alongside
  // --------------------------------------------------------------------------
  logic [QW-1:0] qx, qy;
  pd_t           pd_q [NDIV];

  rgu_divider #(
    .NUM_BITS (QW),
    .DEN_BITS (C),
    .STEP_BITS(RGU_DIV_STEP)
  ) u_div_x (
    .clk_i (clk_i),
    .en_i  (take[SD0 +: NDIV]),
    .num_i (px_q),
    .den_i (dvx_q),
    .quo_o (qx)
  );

  rgu_divider #(
    .NUM_BITS (QW),
    .DEN_BITS (C),
    .STEP_BITS(RGU_DIV_STEP)
  ) u_div_y (
    .clk_i (clk_i),
    .en_i  (take[SD0 +: NDIV]),
    .num_i (py_q),
    .den_i (dvy_q),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (take[SD0]) pd_q[0] <= pc_q;
    for (int k = 1; k < NDIV; k++) begin
      if (take[SD0+k]) pd_q[k] <= pd_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: crossing window compare, then hold for the receiver
  // --------------------------------------------------------------------------
  pd_t pf;
  po_t out_d, out_q;
  logic cross_x, cross_y;

  assign pf = pd_q[NDIV-1];

  always_comb begin
    cross_x = ($signed({2'b00, qx}) >= QS'(pf.lx)) &&
              ($signed({2'b00, qx}) <  QS'(pf.hx));
    cross_y = ($signed({2'b00, qy}) >= QS'(pf.ly)) &&
              ($signed({2'b00, qy}) <  QS'(pf.hy));
    out_d.rx  = pf.rx;
    out_d.ry  = pf.ry;
    out_d.rw  = pf.rw;
    out_d.rh  = pf.rh;
    out_d.hit = pf.pend ? (cross_x || cross_y) : pf.hit;
  end

  always_ff @(posedge clk_i) begin
    if (take[SOUT]) out_q <= out_d;
  end

  assign out_o.valid = valid_q[SOUT];
  assign out_o.r_x   = out_q.rx;
  assign out_o.r_y   = out_q.ry;
  assign out_o.r_w   = out_q.rw;
  assign out_o.r_h   = out_q.rh;
  assign out_o.hit   = out_q.hit;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Any empty stage must leave the input open
  a_ready_on_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> in_i.ready)
    else $error("input stalled with an empty pipeline stage");

  // A pending crossing never reaches the dividers with a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[SC] && pc_q.pend) |-> ((dvx_q != '0) && (dvy_q != '0)))
    else $error("line crossing issued with zero divisor");

  // A blocked stage keeps its transaction
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[SC] && !take[SC + 1]) |=> valid_q[SC])
    else $error("stalled transaction dropped in multiply stage");

endmodule

// File: hdl/rgu_divider.sv
// ----------------------------------------------------------------------------
// rgu_divider
// Pipelined unsigned restoring divider, STEP_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module rgu_divider import rgu_pkg::*; #(
  parameter int unsigned NUM_BITS  = 2 * RGU_COORD_BITS + 1,
  parameter int unsigned DEN_BITS  = RGU_COORD_BITS,
  parameter int unsigned STEP_BITS = RGU_DIV_STEP,
  localparam int unsigned NumStages = (NUM_BITS + STEP_BITS - 1) / STEP_BITS,
  localparam int unsigned ShBits    = NumStages * STEP_BITS
) (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  output logic [NUM_BITS-1:0]  quo_o
);

  logic [DEN_BITS-1:0] rem_q [NumStages];
  logic [ShBits-1:0]   sh_q  [NumStages];
  logic [DEN_BITS-1:0] den_q [NumStages];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in, rem_d, den_in;
    logic [ShBits-1:0]   sh_in, sh_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = ShBits'(num_i);
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign sh_in  = sh_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift dividend bits out of the top, quotient bits in at the bottom
    always_comb begin : p_step
      logic [DEN_BITS:0] trial;
      rem_d = rem_in;
      sh_d  = sh_in;
      trial = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
        trial = {rem_d, sh_d[ShBits-1]};
        sh_d  = {sh_d[ShBits-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d   = DEN_BITS'(trial - {1'b0, den_in});
          sh_d[0] = 1'b1;
        end else begin
          rem_d = trial[DEN_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        sh_q[k]  <= sh_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = sh_q[NumStages-1][NUM_BITS-1:0];

endmodule
